@@ src/gaqs_pkg.sv @@
// Shared constants, codes and divider handshake types of the air quality scorer.
`timescale 1ns / 1ps
package gaqs_pkg;

    localparam int MEDIAN_DEPTH_DEF  = 5;
    localparam int CALIB_SAMPLES_DEF = 120;

    // Divider operand widths: numerator up to 102400 * gas plus rounding, divisor up to 3 * B.
    localparam int NUM_W = 42;
    localparam int DEN_W = 26;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_STORED_BASELINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CALIB_GAS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_HIGH   = 3'd4;

    localparam logic [2:0] STAT_UNKNOWN     = 3'd0;
    localparam logic [2:0] STAT_CALIBRATING = 3'd1;
    localparam logic [2:0] STAT_GOOD        = 3'd2;
    localparam logic [2:0] STAT_MODERATE    = 3'd3;
    localparam logic [2:0] STAT_POOR        = 3'd4;
    localparam logic [2:0] STAT_VERY_POOR   = 3'd5;

    localparam logic [23:0] BASE_MIN    = 24'd26;
    localparam logic [23:0] BASE_MAX    = 24'd2560000;
    localparam logic [14:0] FULL_SCORE  = 15'd25600;
    localparam logic [13:0] PENALTY_CAP = 14'd5120;
    localparam logic [14:0] LEVEL_GOOD  = 15'd19200;
    localparam logic [14:0] LEVEL_MOD   = 15'd12800;
    localparam logic [14:0] LEVEL_POOR  = 15'd6400;

    localparam logic [19:0] WARMUP_RST  = 20'd120000;
    localparam logic [15:0] MIN_GAS_RST = 16'd26;
    localparam logic [14:0] HUM_LOW_RST = 15'd7680;
    localparam logic [14:0] HUM_HI_RST  = 15'd17920;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ src/gaqs_in_if.sv @@
// Input sample channel of the air quality scorer.
`timescale 1ns / 1ps
interface gaqs_in_if;
    logic               valid;
    logic               ready;
    logic [23:0]        gas_kohm;
    logic [14:0]        humidity_rh;
    logic signed [15:0] temperature_c;
    logic               values_valid;
    logic [31:0]        now_ms;

    modport source (output valid, gas_kohm, humidity_rh, temperature_c, values_valid, now_ms,
                    input ready);
    modport sink   (input valid, gas_kohm, humidity_rh, temperature_c, values_valid, now_ms,
                    output ready);
endinterface

@@ src/gaqs_out_if.sv @@
// Result channel of the air quality scorer.
`timescale 1ns / 1ps
interface gaqs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [14:0] score;
    logic [14:0] raw_score;
    logic [14:0] gas_score;
    logic [23:0] baseline_out;
    logic        calibration_done;

    modport source (output valid, status, score, raw_score, gas_score, baseline_out,
                    calibration_done, input ready);
    modport sink   (input valid, status, score, raw_score, gas_score, baseline_out,
                    calibration_done, output ready);
endinterface

@@ src/gaqs_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gaqs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gaqs_pkg::t_div_req i_req,
    output gaqs_pkg::t_div_rsp o_rsp
);
    localparam int NW = gaqs_pkg::NUM_W;
    localparam int DW = gaqs_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // shift in one numerator bit, subtract when it fits
                r_rem <= fits ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
                r_num <= {r_num[NW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule

@@ src/gas_air_quality_scorer.sv @@
// Top level of the gas air quality scorer: sequencer, filters and score arithmetic.
// A fresh scored sample runs the window ranking and the divider; the sample that completes
// calibration runs the divider once more first; invalid, calibrating and repeated ones skip both.
// Throughput: one sample at a time; output register lets the next sample in while a result waits.
// Reset (synchronous, active low) clears filters and loads registers to their defaults;
// writing the stored baseline clears the filters the same way and loads it if in range, else recalibrates.
`timescale 1ns / 1ps
module gas_air_quality_scorer #(
    parameter int MEDIAN_DEPTH  = gaqs_pkg::MEDIAN_DEPTH_DEF,
    parameter int CALIB_SAMPLES = gaqs_pkg::CALIB_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gaqs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gaqs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gaqs_in_if.sink                            i_item,
    gaqs_out_if.source                         o_result
);
    localparam int NW = gaqs_pkg::NUM_W;
    localparam int DW = gaqs_pkg::DEN_W;
    localparam int FW = $clog2(MEDIAN_DEPTH + 1);   // fill count and rank
    localparam int IW = $clog2(MEDIAN_DEPTH);       // window index
    localparam int KW = $clog2(CALIB_SAMPLES + 1);  // calibration count

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_CALDIV, S_FRESH, S_RANK, S_MED, S_GSETUP, S_GDIV, S_FIN, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [19:0] r_warmup;
    logic [15:0] r_min_gas;
    logic [14:0] r_hum_lo;
    logic [14:0] r_hum_hi;

    // latched sample
    logic [23:0] r_gas;
    logic [14:0] r_hum;
    logic [15:0] r_temp;
    logic        r_valid;
    logic [31:0] r_now;

    // filter and calibration state
    logic [23:0] r_win [MEDIAN_DEPTH];
    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_wpos;
    logic [14:0] r_smooth;
    logic        r_sm_valid;
    logic [14:0] r_last_raw;
    logic [14:0] r_last_gs;
    logic [23:0] r_prev_gas;
    logic [14:0] r_prev_hum;
    logic [15:0] r_prev_temp;
    logic        r_prev_valid;
    logic [23:0] r_base;
    logic        r_base_ready;
    logic        r_calibrating;
    logic [31:0] r_sum;
    logic [KW-1:0] r_cnt;
    logic [31:0] r_start;
    logic        r_start_cap;

    // working registers
    logic [IW-1:0] r_idx;
    logic [23:0] r_mlo;
    logic [23:0] r_mhi;
    logic [23:0] r_filt;
    logic        r_ge;
    logic [2:0]  r_res_status;
    logic [14:0] r_res_score;
    logic [14:0] r_res_raw;
    logic [14:0] r_res_gs;
    logic        r_res_done;

    // output register
    logic        r_ovalid;
    logic [2:0]  r_o_status;
    logic [14:0] r_o_score;
    logic [14:0] r_o_raw;
    logic [14:0] r_o_gs;
    logic [23:0] r_o_base;
    logic        r_o_done;

    gaqs_pkg::t_div_req div_req;
    gaqs_pkg::t_div_rsp div_rsp;

    gaqs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    function automatic logic [2:0] level_of(input logic [14:0] s);
        if (s >= gaqs_pkg::LEVEL_GOOD)      return gaqs_pkg::STAT_GOOD;
        else if (s >= gaqs_pkg::LEVEL_MOD)  return gaqs_pkg::STAT_MODERATE;
        else if (s >= gaqs_pkg::LEVEL_POOR) return gaqs_pkg::STAT_POOR;
        else                                return gaqs_pkg::STAT_VERY_POOR;
    endfunction

    // ---- evaluation of a latched sample: warm-up clock and calibration ----
    logic [31:0]   start_eff;
    logic [31:0]   elapsed;
    logic          item_ok;
    logic          cal_take;
    logic [31:0]   n_sum;
    logic [KW-1:0] n_cnt;
    logic          cal_fin;
    logic          fresh;
    logic          cfg_base_ok;

    assign start_eff = (r_calibrating && !r_start_cap) ? r_now : r_start;
    assign elapsed   = r_now - start_eff;
    assign item_ok   = r_valid && (r_gas != 24'd0);
    assign cal_take  = (elapsed >= 32'(r_warmup)) && (r_gas >= 24'(r_min_gas));
    assign n_sum     = r_sum + 32'(r_gas);
    assign n_cnt     = r_cnt + 1'b1;
    assign cal_fin   = n_cnt >= KW'(CALIB_SAMPLES);
    assign fresh     = !r_prev_valid || (r_gas != r_prev_gas) || (r_hum != r_prev_hum)
                       || (r_temp != r_prev_temp);
    assign cfg_base_ok = (i_cfg_data >= gaqs_pkg::BASE_MIN) && (i_cfg_data <= gaqs_pkg::BASE_MAX);

    // ---- stable rank of the window entry under test ----
    logic [FW-1:0] rank;
    logic [FW-1:0] hi_rank;
    logic [23:0]   cand;

    assign cand    = r_win[r_idx];
    assign hi_rank = r_fill >> 1;

    always_comb begin
        rank = '0;
        for (int j = 0; j < MEDIAN_DEPTH; j++) begin
            if ((FW'(j) < r_fill) &&
                ((r_win[j] < cand) || ((r_win[j] == cand) && (IW'(j) < r_idx)))) begin
                rank = rank + 1'b1;
            end
        end
    end

    // ---- gas score operands from the filtered gas and the baseline ----
    logic [NW-1:0] g42;
    logic [NW-1:0] b42;
    logic [NW-1:0] sc_num;
    logic [DW-1:0] sc_den;

    assign g42 = NW'(r_filt);
    assign b42 = NW'(r_base);

    always_comb begin
        if (g42 >= b42) begin
            sc_num = NW'(25600) * (g42 - b42);
            sc_den = DW'(r_base);
        end else if (NW'(10) * g42 >= NW'(9) * b42) begin
            sc_num = NW'(38400) * g42 - NW'(17920) * b42;
            sc_den = DW'(r_base);
        end else if (NW'(4) * g42 >= NW'(3) * b42) begin
            sc_num = NW'(102400) * g42 - NW'(42240) * b42;
            sc_den = DW'(NW'(3) * b42);
        end else if (NW'(2) * g42 >= b42) begin
            sc_num = NW'(25600) * g42 - NW'(7680) * b42;
            sc_den = DW'(r_base);
        end else begin
            sc_num = NW'(10240) * g42;
            sc_den = DW'(r_base);
        end
    end

    always_comb begin
        div_req = '0;
        if (r_state == S_EVAL) begin
            div_req.start = item_ok && r_calibrating && cal_take && cal_fin;
            div_req.num   = NW'(n_sum) + NW'(n_cnt >> 1);
            div_req.den   = DW'(n_cnt);
        end else if (r_state == S_GSETUP) begin
            div_req.start = 1'b1;
            div_req.num   = sc_num + NW'(sc_den >> 1);
            div_req.den   = sc_den;
        end
    end

    // ---- final score: clamp, humidity penalty, smoothing ----
    logic [NW-1:0] sc_full;
    logic [14:0]   n_gs;
    logic [15:0]   hum_dist;
    logic [13:0]   pen_raw;
    logic [13:0]   pen;
    logic [14:0]   n_raw;
    logic [17:0]   ema_sum;
    logic [14:0]   n_smooth;

    assign sc_full = r_ge ? div_rsp.quot + NW'(20480) : div_rsp.quot;
    assign n_gs    = (sc_full > NW'(gaqs_pkg::FULL_SCORE)) ? gaqs_pkg::FULL_SCORE
                                                             : sc_full[14:0];

    always_comb begin
        // the low bound wins when the band is crossed
        if (r_hum < r_hum_lo)      hum_dist = 16'(r_hum_lo - r_hum) + 16'd2;
        else if (r_hum > r_hum_hi) hum_dist = 16'(r_hum - r_hum_hi) + 16'd2;
        else                       hum_dist = 16'd0;
    end

    assign pen_raw  = hum_dist[15:2];
    assign pen      = (pen_raw > gaqs_pkg::PENALTY_CAP) ? gaqs_pkg::PENALTY_CAP : pen_raw;
    assign n_raw    = (n_gs > 15'(pen)) ? n_gs - 15'(pen) : 15'd0;
    assign ema_sum  = (18'(r_smooth) << 1) + 18'(r_smooth) + 18'(n_raw) + 18'd2;
    assign n_smooth = r_sm_valid ? ema_sum[16:2] : n_raw;

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_warmup      <= gaqs_pkg::WARMUP_RST;
            r_min_gas     <= gaqs_pkg::MIN_GAS_RST;
            r_hum_lo      <= gaqs_pkg::HUM_LOW_RST;
            r_hum_hi      <= gaqs_pkg::HUM_HI_RST;
            for (int k = 0; k < MEDIAN_DEPTH; k++) r_win[k] <= '0;
            r_fill        <= '0;
            r_wpos        <= '0;
            r_smooth      <= '0;
            r_sm_valid    <= 1'b0;
            r_last_raw    <= '0;
            r_last_gs     <= '0;
            r_prev_gas    <= '0;
            r_prev_hum    <= '0;
            r_prev_temp   <= '0;
            r_prev_valid  <= 1'b0;
            r_base        <= '0;
            r_base_ready  <= 1'b0;
            r_calibrating <= 1'b1;
            r_sum         <= '0;
            r_cnt         <= '0;
            r_start       <= '0;
            r_start_cap   <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_gas   <= i_item.gas_kohm;
                        r_hum   <= i_item.humidity_rh;
                        r_temp  <= i_item.temperature_c;
                        r_valid <= i_item.values_valid;
                        r_now   <= i_item.now_ms;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // warm-up clock starts on the first sample, valid or not
                    if (r_calibrating && !r_start_cap) begin
                        r_start     <= r_now;
                        r_start_cap <= 1'b1;
                    end
                    r_res_score  <= '0;
                    r_res_raw    <= '0;
                    r_res_gs     <= '0;
                    r_res_done   <= 1'b0;
                    if (!item_ok) begin
                        r_res_status <= gaqs_pkg::STAT_UNKNOWN;
                        r_state      <= S_DONE;
                    end else if (r_calibrating) begin
                        if (cal_take) begin
                            r_sum <= n_sum;
                            r_cnt <= n_cnt;
                        end
                        if (cal_take && cal_fin) begin
                            r_res_status <= gaqs_pkg::STAT_UNKNOWN;
                            r_state      <= S_CALDIV;
                        end else begin
                            r_res_status <= gaqs_pkg::STAT_CALIBRATING;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_res_status <= gaqs_pkg::STAT_UNKNOWN;
                        r_state      <= S_FRESH;
                    end
                end
                S_CALDIV: begin
                    if (div_rsp.done) begin
                        r_base        <= div_rsp.quot[23:0];
                        r_base_ready  <= 1'b1;
                        r_calibrating <= 1'b0;
                        r_res_done    <= 1'b1;
                        r_state       <= S_FRESH;
                    end
                end
                S_FRESH: begin
                    if (!r_base_ready || (r_base == 24'd0)) begin
                        r_res_status <= gaqs_pkg::STAT_CALIBRATING;
                        r_state      <= S_DONE;
                    end else if (fresh) begin
                        r_prev_gas   <= r_gas;
                        r_prev_hum   <= r_hum;
                        r_prev_temp  <= r_temp;
                        r_prev_valid <= 1'b1;
                        r_win[r_wpos] <= r_gas;
                        r_wpos <= (r_wpos == IW'(MEDIAN_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                        if (r_fill < FW'(MEDIAN_DEPTH)) r_fill <= r_fill + 1'b1;
                        r_idx   <= '0;
                        r_state <= S_RANK;
                    end else begin
                        // repeated sample: report the last scores again
                        r_res_score  <= r_smooth;
                        r_res_raw    <= r_last_raw;
                        r_res_gs     <= r_last_gs;
                        r_res_status <= level_of(r_smooth);
                        r_state      <= S_DONE;
                    end
                end
                S_RANK: begin
                    if (rank == hi_rank)        r_mhi <= cand;
                    if (rank == hi_rank - 1'b1) r_mlo <= cand;
                    r_idx <= r_idx + 1'b1;
                    if (FW'(r_idx) == r_fill - 1'b1) r_state <= S_MED;
                end
                S_MED: begin
                    r_filt  <= r_fill[0] ? r_mhi : 24'((25'(r_mlo) + 25'(r_mhi)) >> 1);
                    r_state <= S_GSETUP;
                end
                S_GSETUP: begin
                    r_ge    <= g42 >= b42;
                    r_state <= S_GDIV;
                end
                S_GDIV: begin
                    if (div_rsp.done) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_last_gs    <= n_gs;
                    r_last_raw   <= n_raw;
                    r_smooth     <= n_smooth;
                    r_sm_valid   <= 1'b1;
                    r_res_gs     <= n_gs;
                    r_res_raw    <= n_raw;
                    r_res_score  <= n_smooth;
                    r_res_status <= level_of(n_smooth);
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid || o_result.ready) begin
                        r_o_status <= r_res_status;
                        r_o_score  <= r_res_score;
                        r_o_raw    <= r_res_raw;
                        r_o_gs     <= r_res_gs;
                        r_o_base   <= r_base;
                        r_o_done   <= r_res_done;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // load the output register from the done state, drop it once transferred
            if ((r_state == S_DONE) && (!r_ovalid || o_result.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end

            // configuration writes must arrive only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gaqs_pkg::CFG_STORED_BASELINE: begin
                        for (int k = 0; k < MEDIAN_DEPTH; k++) r_win[k] <= '0;
                        r_fill        <= '0;
                        r_wpos        <= '0;
                        r_smooth      <= '0;
                        r_sm_valid    <= 1'b0;
                        r_last_raw    <= '0;
                        r_last_gs     <= '0;
                        r_prev_gas    <= '0;
                        r_prev_hum    <= '0;
                        r_prev_temp   <= '0;
                        r_prev_valid  <= 1'b0;
                        r_sum         <= '0;
                        r_cnt         <= '0;
                        r_start       <= '0;
                        r_start_cap   <= 1'b0;
                        r_base        <= cfg_base_ok ? i_cfg_data : 24'd0;
                        r_base_ready  <= cfg_base_ok;
                        r_calibrating <= !cfg_base_ok;
                    end
                    gaqs_pkg::CFG_WARMUP_MS:     r_warmup  <= i_cfg_data[19:0];
                    gaqs_pkg::CFG_MIN_CALIB_GAS: r_min_gas <= i_cfg_data[15:0];
                    gaqs_pkg::CFG_HUMIDITY_LOW:  r_hum_lo  <= i_cfg_data[14:0];
                    gaqs_pkg::CFG_HUMIDITY_HIGH: r_hum_hi  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid            = r_ovalid;
    assign o_result.status           = r_o_status;
    assign o_result.score            = r_o_score;
    assign o_result.raw_score        = r_o_raw;
    assign o_result.gas_score        = r_o_gs;
    assign o_result.baseline_out     = r_o_base;
    assign o_result.calibration_done = r_o_done;

`ifndef SYNTH
    a_calib_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calibrating |-> !r_base_ready)
        else $error("calibrating with a ready baseline");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MEDIAN_DEPTH))
        else $error("median fill beyond window depth");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("ready right after a transfer");

    a_calib_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status == gaqs_pkg::STAT_CALIBRATING) |->
            (r_o_gs == 15'd0 && r_o_score == 15'd0))
        else $error("score reported while calibrating");

    a_done_has_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_done) |-> (r_o_base != 24'd0))
        else $error("calibration finished with zero baseline");
`endif
endmodule
